>>> sv/i2cbb_pkg.sv
// Package for the I2C bit-bang master: result word type, command codes,
// sequencer phase encoding and reset defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package i2cbb_pkg;

	localparam int DIVIDER_WIDTH_DEF = 8;
	localparam logic [7:0] PHASE_TICKS_RST = 8'd53;
	localparam logic [7:0] ADDR_MASK = 8'hfe;
	localparam logic [7:0] MSB_MASK = 8'h80;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_STOP  = 3'd4;

	typedef enum logic [15:0] {
		PH_IDLE = 16'h0001,
		PH_ST_A = 16'h0002,
		PH_ST_B = 16'h0004,
		PH_ST_C = 16'h0008,
		PH_ST_D = 16'h0010,
		PH_WB_A = 16'h0020,
		PH_WB_B = 16'h0040,
		PH_RB_A = 16'h0080,
		PH_RB_B = 16'h0100,
		PH_RB_C = 16'h0200,
		PH_RA_A = 16'h0400,
		PH_RA_B = 16'h0800,
		PH_RA_C = 16'h1000,
		PH_SP_A = 16'h2000,
		PH_SP_B = 16'h4000,
		PH_SP_C = 16'h8000
	} phase_t;

	typedef struct packed {
		logic       sda_pull_low;
		logic       scl_pull_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       nack_seen;
		logic       rejected;
	} res_t;

endpackage
`default_nettype wire

>>> sv/i2cbb_seq.sv
// Phase sequencer of the I2C bit-bang master: state registers and the
// per-tick update. Depends on i2cbb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module i2cbb_seq import i2cbb_pkg::*; #(
	parameter int DIVIDER_WIDTH = DIVIDER_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [2:0] operation,
	input  wire logic [7:0] byte_value,
	input  wire logic       read_not_write,
	input  wire logic       ack_after_read,
	input  wire logic       scl_sense,
	input  wire logic       sda_sense,
	input  wire logic [7:0] phase_ticks,
	output res_t            res
);

	localparam int CW = ((DIVIDER_WIDTH > 8) ? DIVIDER_WIDTH : 8) + 1;
	localparam logic [CW-1:0] LIM = CW'(1) << DIVIDER_WIDTH;

	phase_t                   phase_q, phase_d;
	logic [2:0]               cmd_q, cmd_d;
	logic [3:0]               bit_q, bit_d, bit_inc;
	logic [7:0]               shift_q, shift_d;
	logic [DIVIDER_WIDTH-1:0] tick_q, tick_d, tick_inc;
	logic                     held_q, held_d;
	logic                     ackc_q, ackc_d;
	logic                     sda_q, sda_d;
	logic                     scl_q, scl_d;
	logic [7:0]               rd_q, rd_d;
	logic                     nack_q, nack_d;
	logic                     is_cmd, fire, done, rej;
	logic [CW-1:0]            per_raw, per, tick_ext;

	assign is_cmd   = (operation == OP_START) || (operation == OP_WRITE) ||
	                  (operation == OP_READ) || (operation == OP_STOP);
	assign tick_inc = tick_q + DIVIDER_WIDTH'(1);
	assign bit_inc  = bit_q + 4'd1;
	assign per_raw  = (phase_ticks == 8'd0) ? CW'(1) : CW'(phase_ticks);
	assign per      = (per_raw > LIM) ? LIM : per_raw;
	assign tick_ext = CW'(tick_inc);
	assign fire     = (tick_inc == '0) || (tick_ext >= per);

	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		tick_d  = tick_q;
		held_d  = held_q;
		ackc_d  = ackc_q;
		sda_d   = sda_q;
		scl_d   = scl_q;
		rd_d    = rd_q;
		nack_d  = nack_q;
		done    = 1'b0;
		rej     = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (is_cmd) begin
				cmd_d  = operation;
				tick_d = '0;
				bit_d  = 4'd0;
				case (operation)
					OP_START: begin
						shift_d = (byte_value & ADDR_MASK) | {7'd0, read_not_write};
						phase_d = PH_ST_A;
					end
					OP_WRITE: begin
						shift_d = byte_value;
						phase_d = PH_WB_A;
					end
					OP_READ: begin
						shift_d = 8'd0;
						ackc_d  = ack_after_read;
						phase_d = PH_RB_A;
					end
					default: begin
						phase_d = PH_SP_A;
					end
				endcase
			end
		end else begin
			rej    = is_cmd;
			tick_d = tick_inc;
			if (fire) begin
				tick_d = '0;
				case (phase_q)
					PH_ST_A: begin
						if (held_q) begin
							sda_d   = 1'b0;
							phase_d = PH_ST_B;
						end else begin
							sda_d   = 1'b1;
							phase_d = PH_ST_D;
						end
					end
					PH_ST_B: begin
						scl_d   = 1'b0;
						phase_d = PH_ST_C;
					end
					PH_ST_C: begin
						sda_d   = 1'b1;
						phase_d = PH_ST_D;
					end
					PH_ST_D: begin
						scl_d   = 1'b1;
						held_d  = 1'b1;
						bit_d   = 4'd0;
						phase_d = PH_WB_A;
					end
					PH_WB_A: begin
						sda_d   = ((shift_q & MSB_MASK) == 8'd0);
						scl_d   = 1'b0;
						phase_d = PH_WB_B;
					end
					PH_WB_B: begin
						scl_d   = 1'b1;
						shift_d = {shift_q[6:0], 1'b0};
						bit_d   = bit_inc;
						phase_d = bit_inc[3] ? PH_RB_A : PH_WB_A;
					end
					PH_RB_A: begin
						sda_d   = 1'b0;
						scl_d   = 1'b0;
						phase_d = PH_RB_B;
					end
					PH_RB_B: begin
						// slave stretching the clock: wait another phase
						if (scl_sense) begin
							shift_d = {shift_q[6:0], sda_sense};
							phase_d = PH_RB_C;
						end
					end
					PH_RB_C: begin
						scl_d = 1'b1;
						if (cmd_q != OP_READ) begin
							nack_d  = shift_q[0];
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							bit_d = bit_inc;
							if (bit_inc[3]) begin
								rd_d    = shift_q;
								phase_d = PH_RA_A;
							end else begin
								phase_d = PH_RB_A;
							end
						end
					end
					PH_RA_A: begin
						sda_d   = ackc_q;
						phase_d = PH_RA_B;
					end
					PH_RA_B: begin
						scl_d   = 1'b0;
						phase_d = PH_RA_C;
					end
					PH_RA_C: begin
						scl_d   = 1'b1;
						sda_d   = 1'b0;
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
					PH_SP_A: begin
						scl_d   = 1'b1;
						sda_d   = 1'b1;
						phase_d = PH_SP_B;
					end
					PH_SP_B: begin
						scl_d   = 1'b0;
						phase_d = PH_SP_C;
					end
					PH_SP_C: begin
						sda_d   = 1'b0;
						held_d  = 1'b0;
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_comb begin
		res.sda_pull_low = sda_d;
		res.scl_pull_low = scl_d;
		res.busy_res     = (phase_d != PH_IDLE);
		res.done_res     = done;
		res.read_byte    = rd_d;
		res.nack_seen    = nack_d;
		res.rejected     = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= OP_TICK;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			tick_q  <= '0;
			held_q  <= 1'b0;
			ackc_q  <= 1'b0;
			sda_q   <= 1'b0;
			scl_q   <= 1'b0;
			rd_q    <= 8'd0;
			nack_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			tick_q  <= tick_d;
			held_q  <= held_d;
			ackc_q  <= ackc_d;
			sda_q   <= sda_d;
			scl_q   <= scl_d;
			rd_q    <= rd_d;
			nack_q  <= nack_d;
		end
	end

endmodule
`default_nettype wire

>>> sv/i2cbb_outbuf.sv
// Two-deep result buffer (output register plus skid stage) of the I2C
// bit-bang master. Depends on i2cbb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module i2cbb_outbuf import i2cbb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  res_t      push_data,
	output logic      full,
	output logic      out_valid,
	input  wire logic out_stall,
	output res_t      out_data
);

	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_stall) begin
			// hold the presented word, park a new one in the skid stage
			if (push && !skid_valid_q) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_stall) begin
			if (push && !skid_valid_q) begin
				skid_q <= push_data;
			end
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else if (push) begin
			out_q <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> sv/i2c_bitbang_master.sv
// Top level of the I2C bit-bang master: handshake, phase-length register,
// sequencer and result buffer. Depends on i2cbb_pkg, i2cbb_seq, i2cbb_outbuf.
`timescale 1ns / 1ps
`default_nettype none
// Open-drain I2C master driven by one input word per clock tick. Each word
// carries an optional command (start, write byte, read byte, stop) and the
// sampled SCL/SDA levels; each accepted word yields exactly one result word
// with the pull-low drives after this tick, busy/done flags, the last read
// byte, the last acknowledge status and a flag for a command rejected because
// a previous one was still running. A command is taken only while idle; the
// tick that takes it does not count toward the first phase. Each phase lasts
// phase_ticks ticks (zero acts as one, capped at 2**DIVIDER_WIDTH); a read bit
// waits another full phase whenever SCL is still held low by the slave.
// Rate: one word per clock cycle. The sequencer updates all its state in the
// cycle a word is accepted and the result goes into a two-entry output buffer,
// so words flow back to back; in_stall rises only when both buffer entries are
// held by a stalled output. Write phase_ticks through cfg_we/cfg_wdata while
// the block is idle.
module i2c_bitbang_master import i2cbb_pkg::*; #(
	parameter int DIVIDER_WIDTH = DIVIDER_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] operation,
	input  wire logic [7:0] byte_value,
	input  wire logic       read_not_write,
	input  wire logic       ack_after_read,
	input  wire logic       scl_sense,
	input  wire logic       sda_sense,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            sda_pull_low,
	output logic            scl_pull_low,
	output logic            busy_res,
	output logic            done_res,
	output logic [7:0]      read_byte,
	output logic            nack_seen,
	output logic            rejected
);

	logic [7:0] phase_ticks_q;
	logic       accept;
	logic       buf_full;
	res_t       res_d, res_out;

	// phase length register; the user must write it only while idle, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	// take a word whenever the skid stage is free
	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	i2cbb_seq #(
		.DIVIDER_WIDTH(DIVIDER_WIDTH)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.operation     (operation),
		.byte_value    (byte_value),
		.read_not_write(read_not_write),
		.ack_after_read(ack_after_read),
		.scl_sense     (scl_sense),
		.sda_sense     (sda_sense),
		.phase_ticks   (phase_ticks_q),
		.res           (res_d)
	);

	i2cbb_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(res_d),
		.full     (buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (res_out)
	);

	// drop the result word onto its ports
	assign sda_pull_low = res_out.sda_pull_low;
	assign scl_pull_low = res_out.scl_pull_low;
	assign busy_res     = res_out.busy_res;
	assign done_res     = res_out.done_res;
	assign read_byte    = res_out.read_byte;
	assign nack_seen    = res_out.nack_seen;
	assign rejected     = res_out.rejected;

endmodule
`default_nettype wire

>>> test/i2c_bitbang_master_tb.sv
// Self-checking testbench for the I2C bit-bang master: a predictor of the phase sequencer
// checks every result word, under random idling on both channels.
// Depends on i2cbb_pkg and i2c_bitbang_master.
`timescale 1ns / 1ps
module i2c_bitbang_master_tb;
	import i2cbb_pkg::*;

	localparam int DW = DIVIDER_WIDTH_DEF;

	typedef struct {
		logic [2:0] op;
		logic [7:0] value;
		logic       rnw;
		logic       ack;
		logic       scl;
		logic       sda;
		int         gap;
	} tick_word_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] operation = OP_TICK;
	logic [7:0] byte_value = 8'd0;
	logic       read_not_write = 1'b0;
	logic       ack_after_read = 1'b0;
	logic       scl_sense = 1'b1;
	logic       sda_sense = 1'b1;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       sda_pull_low;
	logic       scl_pull_low;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_byte;
	logic       nack_seen;
	logic       rejected;

	i2c_bitbang_master DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.byte_value    (byte_value),
		.read_not_write(read_not_write),
		.ack_after_read(ack_after_read),
		.scl_sense     (scl_sense),
		.sda_sense     (sda_sense),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sda_pull_low  (sda_pull_low),
		.scl_pull_low  (scl_pull_low),
		.busy_res      (busy_res),
		.done_res      (done_res),
		.read_byte     (read_byte),
		.nack_seen     (nack_seen),
		.rejected      (rejected)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Sequencer shadow state, advanced once per accepted tick word.
	logic [7:0]    phase_ticks_cfg = PHASE_TICKS_RST;
	phase_t        sq_phase = PH_IDLE;
	logic [2:0]    sq_cmd = 3'd0;
	logic [3:0]    sq_bits = 4'd0;
	logic [7:0]    sq_shift = 8'd0;
	logic [DW-1:0] sq_ticks = '0;
	logic          sq_held = 1'b0;
	logic          sq_ack = 1'b0;
	logic          sq_sda = 1'b0;
	logic          sq_scl = 1'b0;
	logic [7:0]    sq_last_read = 8'd0;
	logic          sq_last_nack = 1'b0;

	tick_word_t tick_words_pending[$];
	res_t       drive_words_due[$];
	int         words_queued = 0;
	int         mismatch_count = 0;
	int         send_mode = 0;
	int         hold_requests = 0;

	function automatic int phase_len();
		int p;
		p = int'(phase_ticks_cfg);
		if (p == 0) p = 1;
		if (p > (1 << DW)) p = 1 << DW;
		return p;
	endfunction

	// Apply the action that ends the current phase; return 1 when the command completes.
	function automatic logic fire_phase(logic scl_in, logic sda_in);
		logic fin;
		fin = 1'b0;
		case (sq_phase)
		PH_ST_A: begin
			// bus already held: repeated-start preamble first
			if (sq_held) begin
				sq_sda = 1'b0;
				sq_phase = PH_ST_B;
			end else begin
				sq_sda = 1'b1;
				sq_phase = PH_ST_D;
			end
		end
		PH_ST_B: begin
			sq_scl = 1'b0;
			sq_phase = PH_ST_C;
		end
		PH_ST_C: begin
			sq_sda = 1'b1;
			sq_phase = PH_ST_D;
		end
		PH_ST_D: begin
			sq_scl = 1'b1;
			sq_held = 1'b1;
			sq_bits = 4'd0;
			sq_phase = PH_WB_A;
		end
		PH_WB_A: begin
			sq_sda = ((sq_shift & MSB_MASK) == 8'd0);
			sq_scl = 1'b0;
			sq_phase = PH_WB_B;
		end
		PH_WB_B: begin
			sq_scl = 1'b1;
			sq_shift = sq_shift << 1;
			sq_bits = sq_bits + 4'd1;
			sq_phase = (sq_bits >= 4'd8) ? PH_RB_A : PH_WB_A;
		end
		PH_RB_A: begin
			sq_sda = 1'b0;
			sq_scl = 1'b0;
			sq_phase = PH_RB_B;
		end
		PH_RB_B: begin
			// SCL still low means the slave stretches: wait one more phase
			if (scl_in) begin
				sq_shift = {sq_shift[6:0], sda_in};
				sq_phase = PH_RB_C;
			end
		end
		PH_RB_C: begin
			sq_scl = 1'b1;
			if (sq_cmd != OP_READ) begin
				sq_last_nack = sq_shift[0];
				sq_phase = PH_IDLE;
				fin = 1'b1;
			end else begin
				sq_bits = sq_bits + 4'd1;
				if (sq_bits >= 4'd8) begin
					sq_last_read = sq_shift;
					sq_phase = PH_RA_A;
				end else begin
					sq_phase = PH_RB_A;
				end
			end
		end
		PH_RA_A: begin
			sq_sda = sq_ack;
			sq_phase = PH_RA_B;
		end
		PH_RA_B: begin
			sq_scl = 1'b0;
			sq_phase = PH_RA_C;
		end
		PH_RA_C: begin
			sq_scl = 1'b1;
			sq_sda = 1'b0;
			sq_phase = PH_IDLE;
			fin = 1'b1;
		end
		PH_SP_A: begin
			sq_scl = 1'b1;
			sq_sda = 1'b1;
			sq_phase = PH_SP_B;
		end
		PH_SP_B: begin
			sq_scl = 1'b0;
			sq_phase = PH_SP_C;
		end
		PH_SP_C: begin
			sq_sda = 1'b0;
			sq_held = 1'b0;
			sq_phase = PH_IDLE;
			fin = 1'b1;
		end
		default: begin
			sq_phase = PH_IDLE;
		end
		endcase
		return fin;
	endfunction

	// Advance the shadow sequencer by one tick word and build the result word it yields.
	function automatic res_t step_i2c_sequencer(tick_word_t w);
		res_t r;
		logic is_cmd;
		logic fin;
		r = '0;
		fin = 1'b0;
		is_cmd = (w.op >= OP_START) && (w.op <= OP_STOP);
		if (sq_phase == PH_IDLE) begin
			if (is_cmd) begin
				sq_cmd = w.op;
				sq_ticks = '0;
				sq_bits = 4'd0;
				case (w.op)
				OP_START: begin
					sq_shift = (w.value & ADDR_MASK) | {7'd0, w.rnw};
					sq_phase = PH_ST_A;
				end
				OP_WRITE: begin
					sq_shift = w.value;
					sq_phase = PH_WB_A;
				end
				OP_READ: begin
					sq_shift = 8'd0;
					sq_ack = w.ack;
					sq_phase = PH_RB_A;
				end
				default: begin
					sq_phase = PH_SP_A;
				end
				endcase
			end
		end else begin
			r.rejected = is_cmd;
			sq_ticks = sq_ticks + DW'(1);
			if (sq_ticks == '0 || int'(sq_ticks) >= phase_len()) begin
				sq_ticks = '0;
				fin = fire_phase(w.scl, w.sda);
			end
		end
		r.sda_pull_low = sq_sda;
		r.scl_pull_low = sq_scl;
		r.busy_res = (sq_phase != PH_IDLE);
		r.done_res = fin;
		r.read_byte = sq_last_read;
		r.nack_seen = sq_last_nack;
		return r;
	endfunction

	function automatic int draw_gap();
		if (send_mode == 1) return $urandom_range(0, 18);
		if (send_mode == 2 && $urandom_range(0, 4) == 0) return $urandom_range(1, 18);
		return 0;
	endfunction

	// Driver: present queued tick words, each after its own idle gap.
	tick_word_t cur_word;
	int         gap_left = 0;
	logic       gap_armed = 1'b0;

	always @(posedge clk) begin
		logic offer;
		if (arst_n) begin
			offer = in_valid;
			if (in_valid && !in_stall) begin
				drive_words_due.push_back(step_i2c_sequencer(cur_word));
				offer = 1'b0;
			end
			if (!offer && tick_words_pending.size() != 0) begin
				if (!gap_armed) begin
					gap_left = tick_words_pending[0].gap;
					gap_armed = 1'b1;
				end
				if (gap_left == 0) begin
					cur_word = tick_words_pending.pop_front();
					gap_armed = 1'b0;
					operation <= cur_word.op;
					byte_value <= cur_word.value;
					read_not_write <= cur_word.rnw;
					ack_after_read <= cur_word.ack;
					scl_sense <= cur_word.scl;
					sda_sense <= cur_word.sda;
					offer = 1'b1;
				end else begin
					gap_left--;
				end
			end
			in_valid <= offer;
		end
	end

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			if (mismatch_count < 50)
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Monitor: check each result word and stall the output at random.
	int stall_left = 0;
	int recv_mode = 0;
	int results_seen = 0;
	int holds_taken = 0;

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (drive_words_due.size() == 0) begin
					if (mismatch_count < 50)
						$display("%0t: result word with none expected, actual %h", $time,
							{sda_pull_low, scl_pull_low, busy_res, done_res, read_byte,
							nack_seen, rejected});
					mismatch_count++;
				end else begin
					want = drive_words_due.pop_front();
					compare_field("sda_pull_low", int'(want.sda_pull_low),
						int'(sda_pull_low));
					compare_field("scl_pull_low", int'(want.scl_pull_low),
						int'(scl_pull_low));
					compare_field("busy_res", int'(want.busy_res), int'(busy_res));
					compare_field("done_res", int'(want.done_res), int'(done_res));
					compare_field("read_byte", int'(want.read_byte), int'(read_byte));
					compare_field("nack_seen", int'(want.nack_seen), int'(nack_seen));
					compare_field("rejected", int'(want.rejected), int'(rejected));
				end
				results_seen++;
				if (results_seen % 64 == 0) recv_mode = $urandom_range(0, 2);
				if (recv_mode == 1)
					stall_left = $urandom_range(0, 18);
				else if (recv_mode == 2 && $urandom_range(0, 4) == 0)
					stall_left = $urandom_range(1, 18);
				else
					stall_left = 0;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			// long hold-off so the output buffer fills and the input stalls
			if (hold_requests != holds_taken) begin
				holds_taken++;
				stall_left = 150;
			end
			out_stall <= (stall_left != 0);
		end
	end

	task automatic push_word(logic [2:0] op, logic [7:0] value, logic rnw, logic ack,
		logic scl, logic sda);
		tick_word_t w;
		w.op = op;
		w.value = value;
		w.rnw = rnw;
		w.ack = ack;
		w.scl = scl;
		w.sda = sda;
		w.gap = draw_gap();
		tick_words_pending.push_back(w);
		words_queued++;
	endtask

	// Queue a command word followed by tick words; sda_level below zero means random SDA.
	task automatic push_command(logic [2:0] op, logic [7:0] value, logic rnw, logic ack,
		int ticks, int scl_low_odds, int noise_odds, int sda_level);
		logic [2:0] t_op;
		logic       scl;
		logic       sda;
		push_word(op, value, rnw, ack, 1'b1, 1'($urandom_range(0, 1)));
		repeat (ticks) begin
			t_op = OP_TICK;
			if (noise_odds > 0 && $urandom_range(1, noise_odds) == 1)
				t_op = 3'($urandom_range(1, 7));
			scl = !(scl_low_odds > 0 && $urandom_range(1, scl_low_odds) == 1);
			sda = (sda_level < 0) ? 1'($urandom_range(0, 1)) : sda_level[0];
			push_word(t_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), scl, sda);
		end
	endtask

	function automatic int phases_for(logic [2:0] op);
		case (op)
		OP_START: return 23;
		OP_WRITE: return 19;
		OP_READ:  return 27;
		OP_STOP:  return 3;
		default:  return 0;
		endcase
	endfunction

	// Ticks to follow a command; now and then too few, so the next command is rejected.
	function automatic int tick_budget(logic [2:0] op);
		int n;
		n = phases_for(op) * phase_len();
		if ($urandom_range(0, 7) == 0) return $urandom_range(0, n - 1);
		return n + 3 * phase_len() + $urandom_range(0, 4);
	endfunction

	task automatic wait_settled();
		while (tick_words_pending.size() != 0 || in_valid || drive_words_due.size() != 0)
			@(posedge clk);
	endtask

	// Drain every result, then tick the sequencer back to idle.
	task automatic settle_to_idle();
		wait_settled();
		while (sq_phase != PH_IDLE) begin
			repeat (phase_len()) push_word(OP_TICK, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1);
			wait_settled();
		end
	endtask

	task automatic load_phase_ticks(logic [7:0] ticks);
		settle_to_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		phase_ticks_cfg = ticks;
	endtask

	task automatic push_frame();
		logic [2:0] op;
		push_command(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), tick_budget(OP_START), 8, 40, -1);
		repeat ($urandom_range(0, 3)) begin
			op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
			push_command(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), tick_budget(op), 8, 40, -1);
		end
		if ($urandom_range(0, 9) != 0)
			push_command(OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), tick_budget(OP_STOP), 8, 40, -1);
		else
			push_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				$urandom_range(0, 6), 4, 3, -1);
	endtask

	initial begin
		int   base;
		logic [7:0] ticks;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: stop at the reset phase length, with the bus not held.
		send_mode = 0;
		push_command(OP_STOP, 8'h00, 1'b0, 1'b0, 3 * PHASE_TICKS_RST + 2, 0, 0, -1);
		// phase length zero acts as one
		load_phase_ticks(8'd0);
		push_word(OP_TICK, 8'hff, 1'b1, 1'b1, 1'b0, 1'b0);
		push_word(3'd5, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
		push_word(3'd6, 8'hff, 1'b1, 1'b1, 1'b0, 1'b1);
		push_word(3'd7, 8'h55, 1'b0, 1'b1, 1'b1, 1'b0);
		// address with all ones, slave does not acknowledge
		push_command(OP_START, 8'hff, 1'b1, 1'b0, 25, 0, 0, 1);
		push_command(OP_WRITE, 8'h00, 1'b0, 1'b0, 21, 0, 0, 0);
		push_command(OP_WRITE, 8'hff, 1'b1, 1'b1, 21, 0, 0, 1);
		// bus held: repeated start
		push_command(OP_START, 8'h00, 1'b0, 1'b1, 25, 0, 0, 0);
		// slave stretches SCL on read bits
		push_command(OP_READ, 8'h00, 1'b0, 1'b1, 60, 3, 0, -1);
		settle_to_idle();
		push_command(OP_READ, 8'hff, 1'b1, 1'b0, 29, 0, 0, 1);
		push_command(OP_READ, 8'h00, 1'b0, 1'b1, 29, 0, 0, 0);
		// commands while busy are rejected; unknown codes mixed in
		push_command(OP_START, 8'h5a, 1'b1, 1'b0, 30, 0, 3, -1);
		settle_to_idle();
		push_command(OP_STOP, 8'h00, 1'b0, 1'b0, 4, 0, 0, -1);
		push_command(OP_STOP, 8'hff, 1'b1, 1'b1, 4, 0, 0, -1);
		// write and read with no start before them
		push_command(OP_WRITE, 8'ha5, 1'b0, 1'b0, 21, 0, 0, -1);
		push_command(OP_READ, 8'h00, 1'b0, 1'b0, 29, 0, 0, -1);

		// Back to back words against a long output hold-off.
		load_phase_ticks(8'd1);
		repeat (4) push_frame();
		@(posedge clk);
		hold_requests <= hold_requests + 1;

		// Reset phase length, with the sender idling now and then.
		load_phase_ticks(PHASE_TICKS_RST);
		send_mode = 2;
		push_command(OP_STOP, 8'h00, 1'b0, 1'b0, tick_budget(OP_STOP), 8, 40, -1);

		// Random frames over short phase lengths.
		base = words_queued;
		while (words_queued - base < 700) begin
			case ($urandom_range(0, 5))
			0: ticks = 8'd0;
			1: ticks = 8'd1;
			2: ticks = 8'd2;
			3: ticks = 8'd3;
			default: ticks = 8'($urandom_range(1, 6));
			endcase
			load_phase_ticks(ticks);
			send_mode = $urandom_range(0, 2);
			repeat ($urandom_range(3, 8))
				if (words_queued - base < 700) push_frame();
		end

		wait_settled();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("i2c_bitbang_master_tb: clean");
		else
			$display("i2c_bitbang_master_tb: errors");
		$finish;
	end

	initial begin
		#5000000;
		$display("i2c_bitbang_master_tb: errors");
		$finish;
	end

endmodule
